### rtl/core/gsps_pkg.sv
// shared types, constants and token builders for the guide star pixel select block
package gsps_pkg;

  localparam int ITERS = 22;
  localparam int XY_W  = 34;
  localparam int Z_W   = 26;
  localparam int ANG_W = 24;
  localparam int ACC_W = 68;
  localparam int NUM_W = 52;
  localparam int DEN_W = 26;

  localparam logic signed [Z_W-1:0]  HALF_TURN    = 26'sd8388608;
  localparam logic signed [Z_W-1:0]  QUARTER_TURN = 26'sd4194304;
  localparam logic signed [XY_W-1:0] CORDIC_K     = 34'sd652032874;

  localparam int CENTER_X = 812;
  localparam int CENTER_Y = 500;
  localparam int WIN_X_LO = 700;
  localparam int WIN_X_HI = 924;
  localparam int WIN_Y_LO = 200;
  localparam int WIN_Y_HI = 800;

  // arctangent of 2^-i in 1/2^24 turn
  localparam logic [ANG_W-1:0] ATAN_TAB [ITERS] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304, 24'd652,
    24'd326, 24'd163, 24'd81, 24'd41, 24'd20, 24'd10, 24'd5, 24'd3, 24'd1
  };

  typedef enum logic [1:0] {TAG_PA1, TAG_PA0, TAG_TILT, TAG_ROT} tag_e;

  typedef enum logic [2:0] {
    REG_ROT_X, REG_ROT_Y, REG_GOFF_X, REG_GOFF_Y,
    REG_GANGLE, REG_SCALE_X, REG_SCALE_Y, REG_SKIP
  } cfg_reg_e;

  // sequencer states of the top level
  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_WAIT1, S_ROT, S_WAIT2, S_MAC,
    S_DX_ST, S_DX, S_DY_ST, S_DY, S_DONE
  } state_e;

  // one vector moving down the cordic row
  typedef struct packed {
    logic                   vld;
    logic                   vec;   // 1: vectoring (atan2), 0: rotation (sin/cos)
    logic                   flag;  // vectoring: zero vector, rotation: negate result
    tag_e                   tag;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_tok_t;

  // atan2 token with left half-plane folded over
  function automatic cordic_tok_t vec_tok(input logic signed [24:0] y,
                                          input logic signed [24:0] x,
                                          input tag_e tag);
    cordic_tok_t t;
    logic        neg;
    neg    = (x < 0);
    t.vld  = 1'b1;
    t.vec  = 1'b1;
    t.flag = (x == 25'sd0) && (y == 25'sd0);
    t.tag  = tag;
    t.x    = neg ? -XY_W'(x) : XY_W'(x);
    t.y    = neg ? -XY_W'(y) : XY_W'(y);
    t.z    = neg ? HALF_TURN : '0;
    return t;
  endfunction

  // sin/cos token with angles beyond a quarter turn folded by half a turn
  function automatic cordic_tok_t rot_tok(input logic [15:0] a, input tag_e tag);
    cordic_tok_t              t;
    logic signed [ANG_W-1:0]  z24;
    logic signed [Z_W-1:0]    z;
    logic                     neg;
    z24 = $signed({a, 8'h00});
    z   = Z_W'(z24);
    neg = 1'b0;
    if (z > QUARTER_TURN) begin
      z   = z - HALF_TURN;
      neg = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z   = z + HALF_TURN;
      neg = 1'b1;
    end
    t.vld  = 1'b1;
    t.vec  = 1'b0;
    t.flag = neg;
    t.tag  = tag;
    t.x    = CORDIC_K;
    t.y    = '0;
    t.z    = z;
    return t;
  endfunction

endpackage

### rtl/core/guide_star_pixel_select_unit.sv
// guide star pixel select: position angle, guider pixel position, window count
// one star in flight at a time; the steps after its input
// transfer: three tokens and then one more go down the 22-cell cordic row, an
// 11-step multiply-accumulate sequence follows, then two divisions.
// next star taken the cycle after the output register loads
// reset clears the count and loads the register defaults (scales 4096, rest zero).
module guide_star_pixel_select_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // star_ra_offset[23:0], star_dec_offset[47:24], star_magnitude[63:48]
  input  logic [63:0] s_axis_tdata_i,
  // new_search[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_x[15:0], pixel_y[31:16], position_angle[47:32], good_count[56:48],
  // magnitude_out[72:57], zero fill[79:73]
  output logic [79:0] m_axis_tdata_o,
  // in_window[0], selected[1]
  output logic [1:0]  m_axis_tuser_o
);
  import gsps_pkg::*;

  localparam logic signed [ACC_W-1:0] RND26 = ACC_W'(33554432);
  localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
  localparam logic signed [53:0] OFF_X = 54'(CENTER_X * 16);
  localparam logic signed [53:0] OFF_Y = 54'(CENTER_Y * 16);

  state_e state_q, state_d;

  // configuration registers
  logic signed [23:0] rcx_q, rcy_q, gox_q, goy_q;
  logic [15:0]        gangle_q, scx_q, scy_q;
  logic [7:0]         skip_q;
  logic [8:0]         window_count_q;

  // star registers
  logic signed [23:0] ra_q, dec_q;
  logic [15:0]        mag_q;
  logic               new_q;

  logic [1:0]         issue_cnt_q;
  logic [3:0]         step_q;
  logic [ANG_W-1:0]   pa1_q, pa0_q;
  logic [15:0]        pa16_q, pa16;
  logic signed [XY_W-1:0] c_q, s_q, ct_q, st_q, rx_q, ry_q;
  logic signed [ACC_W-1:0] prod_q, acc_q;
  logic signed [NUM_W-1:0] tx_q, ty_q;
  logic [NUM_W-1:0]   qx_q, qy_q;

  logic               out_vld_q, out_inwin_q, out_sel_q;
  logic [15:0]        out_px_q, out_py_q, out_pa_q, out_mag_q;
  logic [8:0]         out_cnt_q;

  cordic_tok_t        issue_tok;
  cordic_tok_t        chain [ITERS+1];
  cordic_tok_t        tok_out;
  logic               div_start, div_done, out_load, in_take;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcx_q    <= '0;
      rcy_q    <= '0;
      gox_q    <= '0;
      goy_q    <= '0;
      gangle_q <= '0;
      scx_q    <= 16'd4096;
      scy_q    <= 16'd4096;
      skip_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROT_X:   rcx_q    <= $signed(cfg_data_i);
        REG_ROT_Y:   rcy_q    <= $signed(cfg_data_i);
        REG_GOFF_X:  gox_q    <= $signed(cfg_data_i);
        REG_GOFF_Y:  goy_q    <= $signed(cfg_data_i);
        REG_GANGLE:  gangle_q <= cfg_data_i[15:0];
        REG_SCALE_X: scx_q    <= cfg_data_i[15:0];
        REG_SCALE_Y: scy_q    <= cfg_data_i[15:0];
        REG_SKIP:    skip_q   <= cfg_data_i[7:0];
        default:     skip_q   <= skip_q;
      endcase
    end
  end

  // cordic row
  assign chain[0] = issue_tok;
  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    gsps_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[g]),
      .shift_i (5'(g)),
      .tok_o   (chain[g+1])
    );
  end
  assign tok_out = chain[ITERS];

  gsps_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // position angle difference rounded to 1/65536 turn
  logic [ANG_W-1:0] pa_diff;
  logic [ANG_W:0]   pa_sum;
  always_comb begin
    pa_diff = pa1_q - pa0_q;
    pa_sum  = {1'b0, pa_diff} + 25'd128;
    pa16    = pa_sum[23:8];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_ISSUE;
      S_ISSUE: if (issue_cnt_q == 2'd2) state_d = S_WAIT1;
      S_WAIT1: if (tok_out.vld && tok_out.tag == TAG_TILT) state_d = S_ROT;
      S_ROT:   state_d = S_WAIT2;
      S_WAIT2: if (tok_out.vld && tok_out.tag == TAG_ROT) state_d = S_MAC;
      S_MAC:   if (step_q == 4'd10) state_d = S_DX_ST;
      S_DX_ST: state_d = S_DX;
      S_DX:    if (div_done) state_d = S_DY_ST;
      S_DY_ST: state_d = S_DY;
      S_DY:    if (div_done) state_d = S_DONE;
      S_DONE:  if (!out_vld_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue_tok = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    in_take   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_take = s_axis_tvalid_i;
      S_ISSUE: begin
        unique case (issue_cnt_q)
          2'd0:    issue_tok = vec_tok(25'(dec_q) + 25'(rcy_q),
                                       25'(rcx_q) - 25'(ra_q), TAG_PA1);
          2'd1:    issue_tok = vec_tok(25'(goy_q), 25'(gox_q), TAG_PA0);
          default: issue_tok = rot_tok(gangle_q, TAG_TILT);
        endcase
      end
      S_ROT:   issue_tok = rot_tok(pa16, TAG_ROT);
      S_DX_ST, S_DY_ST: div_start = 1'b1;
      S_DONE:  out_load = !out_vld_q || m_axis_tready_i;
      default: issue_tok = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_cnt_q <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ISSUE) issue_cnt_q <= issue_cnt_q + 2'd1;
      else                    issue_cnt_q <= '0;
      if (state_q == S_MAC)   step_q <= step_q + 4'd1;
      else                    step_q <= '0;
    end
  end

  // star capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ra_q  <= $signed(s_axis_tdata_i[23:0]);
      dec_q <= $signed(s_axis_tdata_i[47:24]);
      mag_q <= s_axis_tdata_i[63:48];
      new_q <= s_axis_tuser_i;
    end
  end

  // results leaving the cordic row
  always_ff @(posedge clk_i) begin
    if (tok_out.vld) begin
      case (tok_out.tag)
        TAG_PA1:  pa1_q <= tok_out.flag ? '0 : tok_out.z[ANG_W-1:0];
        TAG_PA0:  pa0_q <= tok_out.flag ? '0 : tok_out.z[ANG_W-1:0];
        TAG_TILT: begin
          ct_q <= tok_out.flag ? -tok_out.x : tok_out.x;
          st_q <= tok_out.flag ? -tok_out.y : tok_out.y;
        end
        default: begin
          c_q <= tok_out.flag ? -tok_out.x : tok_out.x;
          s_q <= tok_out.flag ? -tok_out.y : tok_out.y;
        end
      endcase
    end
    if (state_q == S_ROT) pa16_q <= pa16;
  end

  // multiply operand select, one product per step
  logic signed [XY_W-1:0]  opa, opb, ra_x, dec_x;
  logic signed [24:0]      dcx, dcy;
  logic signed [ACC_W-1:0] base_x, base_y, rnd26, tx_full;
  always_comb begin
    ra_x  = XY_W'(ra_q);
    dec_x = XY_W'(dec_q);
    opa   = '0;
    opb   = '0;
    case (step_q)
      4'd0: begin opa = -ra_x; opb = c_q;  end
      4'd1: begin opa = dec_x; opb = s_q;  end
      4'd2: begin opa = ra_x;  opb = s_q;  end
      4'd3: begin opa = dec_x; opb = c_q;  end
      4'd5: begin opa = rx_q;  opb = ct_q; end
      4'd6: begin opa = -ry_q; opb = st_q; end
      4'd7: begin opa = -rx_q; opb = st_q; end
      4'd8: begin opa = -ry_q; opb = ct_q; end
      default: begin opa = '0; opb = '0; end
    endcase
    dcx     = 25'(rcx_q) - 25'(gox_q);
    dcy     = 25'(rcy_q) - 25'(goy_q);
    base_x  = ACC_W'(dcx) <<< 30;
    base_y  = ACC_W'(dcy) <<< 30;
    rnd26   = (acc_q + RND26) >>> 26;
    tx_full = (acc_q + RND16) >>> 16;
  end

  // multiply-accumulate sequence: rotator frame, then guider tilt
  always_ff @(posedge clk_i) begin
    if (state_q == S_MAC) begin
      prod_q <= ACC_W'(opa) * ACC_W'(opb);
      case (step_q)
        4'd1:  acc_q <= base_x + prod_q;
        4'd2:  acc_q <= acc_q + prod_q;
        4'd3: begin
          rx_q  <= rnd26[XY_W-1:0];
          acc_q <= base_y + prod_q;
        end
        4'd4:  acc_q <= acc_q + prod_q;
        4'd5:  ry_q  <= rnd26[XY_W-1:0];
        4'd6:  acc_q <= prod_q;
        4'd7:  acc_q <= acc_q + prod_q;
        4'd8: begin
          tx_q  <= tx_full[NUM_W-1:0];
          acc_q <= prod_q;
        end
        4'd9:  acc_q <= acc_q + prod_q;
        4'd10: ty_q  <= tx_full[NUM_W-1:0];
        default: acc_q <= acc_q;
      endcase
    end
  end

  // divider operands: rounded magnitude over scale, zero scale as one
  logic [15:0]      sc_eff;
  logic [NUM_W-1:0] t_abs;
  always_comb begin
    if (state_q == S_DX_ST) begin
      sc_eff = (scx_q == 16'd0) ? 16'd1 : scx_q;
      t_abs  = tx_q[NUM_W-1] ? NUM_W'(-tx_q) : NUM_W'(tx_q);
    end else begin
      sc_eff = (scy_q == 16'd0) ? 16'd1 : scy_q;
      t_abs  = ty_q[NUM_W-1] ? NUM_W'(-ty_q) : NUM_W'(ty_q);
    end
    div_den = {sc_eff, 10'd0};
    div_num = t_abs + NUM_W'({sc_eff, 9'd0});
  end

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == S_DX) qx_q <= div_quot;
    if (div_done && state_q == S_DY) qy_q <= div_quot;
  end

  // pixel position, window test, saturation and count
  logic signed [53:0] qx_s, qy_s, px, py;
  logic               inwin, inc;
  logic [8:0]         cnt_base, cnt_new;
  logic [15:0]        px_sat, py_sat;
  always_comb begin
    qx_s = $signed({2'b00, qx_q});
    qy_s = $signed({2'b00, qy_q});
    px   = (tx_q[NUM_W-1] ? -qx_s : qx_s) + OFF_X;
    py   = (ty_q[NUM_W-1] ? -qy_s : qy_s) + OFF_Y;
    inwin = (px > 54'(WIN_X_LO * 16)) && (px < 54'(WIN_X_HI * 16)) &&
            (py > 54'(WIN_Y_LO * 16)) && (py < 54'(WIN_Y_HI * 16));
    if (px > 54'sd32767)       px_sat = 16'h7FFF;
    else if (px < -54'sd32768) px_sat = 16'h8000;
    else                       px_sat = px[15:0];
    if (py > 54'sd32767)       py_sat = 16'h7FFF;
    else if (py < -54'sd32768) py_sat = 16'h8000;
    else                       py_sat = py[15:0];
    cnt_base = new_q ? 9'd0 : window_count_q;
    inc      = inwin && !cnt_base[8];
    cnt_new  = inc ? cnt_base + 9'd1 : cnt_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q      <= 1'b0;
      window_count_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q      <= 1'b1;
        window_count_q <= cnt_new;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_px_q    <= px_sat;
      out_py_q    <= py_sat;
      out_pa_q    <= pa16_q;
      out_inwin_q <= inwin;
      out_cnt_q   <= cnt_new;
      out_sel_q   <= inc && (cnt_base == {1'b0, skip_q});
      out_mag_q   <= mag_q;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_mag_q, out_cnt_q, out_pa_q, out_py_q, out_px_q};
  assign m_axis_tuser_o  = {out_sel_q, out_inwin_q};

endmodule

### rtl/core/gsps_cordic_cell.sv
// one cordic micro-rotation cell, registered, in vectoring or rotation mode
module gsps_cordic_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gsps_pkg::cordic_tok_t tok_i,
  input  logic [4:0]           shift_i,
  output gsps_pkg::cordic_tok_t tok_o
);
  import gsps_pkg::*;

  cordic_tok_t             tok_d, tok_q;
  logic signed [XY_W-1:0]  xs, ys;
  logic signed [Z_W-1:0]   ang;
  logic                    dir_neg;

  // one micro-rotation, direction from y sign or residual angle
  always_comb begin
    xs      = tok_i.x >>> shift_i;
    ys      = tok_i.y >>> shift_i;
    ang     = $signed({2'b00, ATAN_TAB[shift_i]});
    dir_neg = tok_i.vec ? (tok_i.y > 0) : (tok_i.z < 0);
    tok_d   = tok_i;
    if (dir_neg) begin
      tok_d.x = tok_i.x + ys;
      tok_d.y = tok_i.y - xs;
      tok_d.z = tok_i.z + ang;
    end else begin
      tok_d.x = tok_i.x - ys;
      tok_d.y = tok_i.y + xs;
      tok_d.z = tok_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/core/gsps_divider.sv
// restoring divider, one quotient bit per cycle
module gsps_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gsps_pkg::NUM_W-1:0]  num_i,
  input  logic [gsps_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [gsps_pkg::NUM_W-1:0]  quot_o
);
  import gsps_pkg::*;

  logic                 busy_q, done_q;
  logic [5:0]           cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [DEN_W:0]       trial;
  logic                 qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
